// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge outside reset
`define AST_HOLDS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lzwdc_pkg.sv =====
package lzwdc_pkg;

	localparam int MAX_CODES     = 4096;
	localparam int CODE_W        = $clog2(MAX_CODES);
	localparam int CNT_W         = CODE_W + 1;
	localparam int LIMIT_W       = 13;
	localparam int BITS_W        = 4;
	localparam int BYTE_W        = 8;
	localparam int EPOCH_W       = 4;
	localparam int SLOT_W        = EPOCH_W + 2 * CODE_W + BYTE_W;
	localparam int FIRST_LEARNED = 257;
	localparam int MIN_LIMIT     = 258;

	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		code_t              prefix;
		logic [BYTE_W-1:0]  sym;
		code_t              code;
	} slot_t;

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (32'(v) < MIN_LIMIT) begin
			r = CNT_W'(MIN_LIMIT);
		end else if (32'(v) > MAX_CODES) begin
			r = CNT_W'(MAX_CODES);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	// smallest w with 2^w >= lim
	function automatic logic [BITS_W-1:0] code_width(input logic [CNT_W-1:0] lim);
		logic [BITS_W-1:0] w;
		w = BITS_W'(CODE_W);
		for (int i = CODE_W - 1; i >= 0; i--) begin
			if ((32'd1 << i) >= 32'(lim)) begin
				w = BITS_W'(i);
			end
		end
		return w;
	endfunction

	function automatic code_t hash_of(input code_t pre, input logic [BYTE_W-1:0] b);
		return pre ^ (code_t'(b) << (CODE_W - BYTE_W));
	endfunction

endpackage

// ===== hw/rtl/lzw_dictionary_compressor_core.sv =====
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+---------------------------
// item in  | op, data_byte                             | item_valid / item_stall
// code out | code, code_bits, last                     | code_valid / code_stall
// config   | cfg_wr_data (dict_limit)                  | cfg_wr_en, no wait
//
// one item at a time; the dictionary is a linear-probe hash table in one ram,
// one probe per cycle: a byte is transferred, then, if a prefix is held, probed slot by slot until
// a hit or an empty slot, plus an emit step on a miss; an end emits any prefix, then the end mark
// after reset, and after every 16th dictionary clear, a sweep pass
// zeroes the table; items stall during it, config writes still land
// a held output stalls only the emit step; the next item transfers meanwhile
`include "assert_macros.svh"

module lzw_dictionary_compressor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lzwdc_pkg::LIMIT_W-1:0]   cfg_wr_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            op,
	input  logic [lzwdc_pkg::BYTE_W-1:0]    data_byte,
	output logic                            code_valid,
	input  logic                            code_stall,
	output logic [lzwdc_pkg::CODE_W-1:0]    code,
	output logic [lzwdc_pkg::BITS_W-1:0]    code_bits,
	output logic                            last
);

	import lzwdc_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_PROBE,
		S_MISS,
		S_END_PREFIX,
		S_END_MARK
	} state_t;

	state_t              state_q;
	code_t               sweep_q;
	code_t               probe_q;
	logic [BYTE_W-1:0]   sym_q;
	code_t               prefix_q;
	logic                have_prefix_q;
	logic [CNT_W-1:0]    next_code_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [CNT_W-1:0]    lim_q;
	logic [BITS_W-1:0]   bits_q;
	logic                code_valid_q;
	code_t               code_q;
	logic [BITS_W-1:0]   code_bits_q;
	logic                last_q;

	logic                item_take;
	logic                out_free;
	logic                emit;
	logic                can_learn;
	logic [CNT_W-1:0]    cfg_lim;
	logic [SLOT_W-1:0]   ram_rdata;
	slot_t               rd_slot;
	logic                slot_live;
	logic                slot_hit;
	code_t               ram_raddr;
	logic                ram_we;
	code_t               ram_waddr;
	slot_t               wr_slot;

	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign out_free   = !code_valid_q || !code_stall;
	assign emit       = out_free && ((state_q == S_MISS) || (state_q == S_END_PREFIX) ||
	                                 (state_q == S_END_MARK));
	assign can_learn  = (next_code_q < lim_q);
	assign cfg_lim    = clamp_limit(cfg_wr_data);

	assign rd_slot   = slot_t'(ram_rdata);
	assign slot_live = (rd_slot.epoch == epoch_q) && (rd_slot.code != '0);
	assign slot_hit  = slot_live && (rd_slot.prefix == prefix_q) && (rd_slot.sym == sym_q);

	assign ram_raddr = (state_q == S_IDLE) ? hash_of(prefix_q, data_byte)
	                                       : probe_q + code_t'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = probe_q;
		wr_slot   = '0;
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
		end else if (state_q == S_MISS && out_free && can_learn) begin
			ram_we         = 1'b1;
			wr_slot.epoch  = epoch_q;
			wr_slot.prefix = prefix_q;
			wr_slot.sym    = sym_q;
			wr_slot.code   = next_code_q[CODE_W-1:0];
		end
	end

	lzwdc_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_CODES)
	) u_dict (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_slot),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			sweep_q       <= '0;
			probe_q       <= '0;
			sym_q         <= '0;
			prefix_q      <= '0;
			have_prefix_q <= 1'b0;
			next_code_q   <= CNT_W'(FIRST_LEARNED);
			epoch_q       <= '0;
			lim_q         <= CNT_W'(MAX_CODES);
			bits_q        <= BITS_W'(CODE_W);
			code_valid_q  <= 1'b0;
			code_q        <= '0;
			code_bits_q   <= '0;
			last_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lim_q  <= cfg_lim;
				bits_q <= code_width(cfg_lim);
			end
			if (emit) begin
				code_valid_q <= 1'b1;
			end else if (!code_stall) begin
				code_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + code_t'(1);
					if (sweep_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_take) begin
						if (op_t'(op) == OP_END) begin
							state_q <= have_prefix_q ? S_END_PREFIX : S_END_MARK;
						end else if (!have_prefix_q) begin
							prefix_q      <= code_t'(data_byte) + code_t'(1);
							have_prefix_q <= 1'b1;
						end else begin
							sym_q   <= data_byte;
							probe_q <= ram_raddr;
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (slot_hit) begin
						prefix_q <= rd_slot.code;
						state_q  <= S_IDLE;
					end else if (slot_live) begin
						probe_q <= ram_raddr;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (out_free) begin
						code_q       <= prefix_q;
						code_bits_q  <= bits_q;
						last_q       <= 1'b0;
						prefix_q     <= code_t'(sym_q) + code_t'(1);
						if (can_learn) begin
							next_code_q <= next_code_q + CNT_W'(1);
							state_q     <= S_IDLE;
						end else begin
							next_code_q <= CNT_W'(FIRST_LEARNED);
							epoch_q     <= epoch_q + EPOCH_W'(1);
							state_q     <= (epoch_q == '1) ? S_SWEEP : S_IDLE;
						end
					end
				end
				S_END_PREFIX: begin
					if (out_free) begin
						code_q       <= prefix_q;
						code_bits_q  <= bits_q;
						last_q       <= 1'b0;
						state_q      <= S_END_MARK;
					end
				end
				S_END_MARK: begin
					if (out_free) begin
						code_q        <= '0;
						code_bits_q   <= bits_q;
						last_q        <= 1'b1;
						prefix_q      <= '0;
						have_prefix_q <= 1'b0;
						next_code_q   <= CNT_W'(FIRST_LEARNED);
						epoch_q       <= epoch_q + EPOCH_W'(1);
						state_q       <= (epoch_q == '1) ? S_SWEEP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign code_valid = code_valid_q;
	assign code       = code_q;
	assign code_bits  = code_bits_q;
	assign last       = last_q;

	`AST_HOLDS(a_next_code_bound, clk, arst_n, next_code_q <= CNT_W'(MAX_CODES), "next code past table")
	`AST_IMPLIES(a_prefix_set, clk, arst_n, have_prefix_q, prefix_q != '0, "live prefix is zero")
	`AST_IMPLIES(a_last_is_end, clk, arst_n, code_valid_q && last_q, code_q == '0, "last code not zero")
	`AST_IMPLIES(a_learn_in_range, clk, arst_n, ram_we && state_q == S_MISS, next_code_q < lim_q, "learn past limit")

endmodule

// ===== hw/rtl/lzwdc_ram.sv =====
module lzwdc_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
